[hw/rtl/fm_phase_oscillator_top_defines.svh]
// ----------------------------------------------------------------------------
// fm_phase_oscillator_top_defines.svh
// Assertion macros shared by the oscillator RTL. The enclosing module must
// provide clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef FM_PHASE_OSCILLATOR_TOP_DEFINES_SVH
`define FM_PHASE_OSCILLATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define FMOSC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define FMOSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/fmosc_pkg.sv]
// ----------------------------------------------------------------------------
// fmosc_pkg
// Types and constants of the FM phase-accumulator oscillator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fmosc_pkg;

	localparam int STEP_W  = 24;
	localparam int FM_W    = 16;
	localparam int WAVE_W  = 25;
	localparam int SHAPE_W = 2;
	localparam int GAIN_W  = 16;
	localparam int PROD_W  = STEP_W + GAIN_W;
	localparam int EFF_W   = PROD_W - (FM_W - 1);

	typedef logic        [STEP_W-1:0]  step_t;
	typedef logic signed [FM_W-1:0]    fm_t;
	typedef logic signed [WAVE_W-1:0]  wave_t;
	typedef logic        [SHAPE_W-1:0] shape_t;

	// Waveform select codes; the last code runs as triangle
	localparam shape_t SHAPE_SAW   = 2'd0;
	localparam shape_t SHAPE_PULSE = 2'd1;
	localparam shape_t SHAPE_TRI   = 2'd2;
	localparam shape_t SHAPE_SINE  = 2'd3;

	// Output full scale is 2^24, limited to plus/minus one half
	localparam wave_t OUT_HALF = 25'sd8388608;

endpackage

[hw/rtl/fmosc_if.sv]
// ----------------------------------------------------------------------------
// fmosc_if
// Valid/ready channels of the oscillator: step input and sample output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fmosc_in_if;
	import fmosc_pkg::*;

	logic  valid;
	logic  ready;
	step_t phase_step;
	fm_t   fm_sample;

	modport source (output valid, output phase_step, output fm_sample, input ready);
	modport sink   (input valid, input phase_step, input fm_sample, output ready);
endinterface

interface fmosc_out_if;
	import fmosc_pkg::*;

	logic  valid;
	logic  ready;
	wave_t wave_sample;

	modport source (output valid, output wave_sample, input ready);
	modport sink   (input valid, input wave_sample, output ready);
endinterface

[hw/rtl/fm_phase_oscillator_top.sv]
// ----------------------------------------------------------------------------
// fm_phase_oscillator_top: FM phase-accumulator oscillator (saw/pulse/triangle)
// The input stage and then the output register lie between an input transaction and
// output valid; one transaction per cycle while the output is not stalled.
// Async active-low reset clears phase, direction, shape and valid flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "fm_phase_oscillator_top_defines.svh"

module fm_phase_oscillator_top #(
	parameter int PHASE_FRAC_BITS = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  fmosc_pkg::shape_t cfg_wdata,
	fmosc_in_if.sink         step_ch,
	fmosc_out_if.source      wave_ch
);
	import fmosc_pkg::*;

	localparam int ACC_BITS = PHASE_FRAC_BITS + 4;
	localparam int SW       = ((ACC_BITS > EFF_W + 3) ? ACC_BITS : EFF_W + 3) + 2;
	localparam int DN_SH    = (PHASE_FRAC_BITS >= 24) ? PHASE_FRAC_BITS - 24 : 0;
	localparam int UP_SH    = (PHASE_FRAC_BITS < 24) ? 24 - PHASE_FRAC_BITS : 0;

	localparam logic signed [SW-1:0] ONE_SW  = {{(SW-1){1'b0}}, 1'b1};
	localparam logic signed [SW-1:0] HALF_SW = ONE_SW <<< (PHASE_FRAC_BITS - 1);
	localparam logic signed [SW-1:0] FULL_SW = ONE_SW <<< PHASE_FRAC_BITS;
	localparam logic signed [SW-1:0] OUT_HALF_SW = SW'(OUT_HALF);

	// Control and state
	shape_t              wave_shape_q;
	logic [ACC_BITS-1:0] phase_acc_q;
	logic                tri_falling_q;
	logic                valid_s1;
	logic                out_valid_q;

	// Payload
	step_t step_s1;
	fm_t   fm_s1;
	wave_t wave_q;

	// Datapath
	logic                 adv;
	logic                 in_ready;
	logic [GAIN_W-1:0]    gain;
	logic [PROD_W-1:0]    prod;
	logic [EFF_W-1:0]     eff;
	logic signed [SW-1:0] ph_ext;
	logic signed [SW-1:0] eff_ext;
	logic signed [SW-1:0] eff2_ext;
	logic signed [SW-1:0] sum;
	logic [ACC_BITS-1:0]  acc_next;
	logic signed [SW-1:0] wr_ext;
	logic signed [SW-1:0] clamped;
	logic signed [SW-1:0] scaled;
	logic                 tri_next;
	wave_t                wave_next;

	// Handshake: output register frees the input stage
	assign adv      = !out_valid_q || wave_ch.ready;
	assign in_ready = !valid_s1 || adv;

	assign step_ch.ready       = in_ready;
	assign wave_ch.valid       = out_valid_q;
	assign wave_ch.wave_sample = wave_q;

	// Effective step = step * (1 + fm), gain = 32768 + fm
	always_comb begin
		gain     = {~fm_s1[FM_W-1], fm_s1[FM_W-2:0]};
		prod     = PROD_W'(step_s1) * PROD_W'(gain);
		eff      = prod[PROD_W-1:FM_W-1];
		ph_ext   = {{(SW-ACC_BITS){phase_acc_q[ACC_BITS-1]}}, phase_acc_q};
		eff_ext  = {{(SW-EFF_W){1'b0}}, eff};
		eff2_ext = eff_ext <<< 1;
	end

	// Phase update, direction and saturation
	always_comb begin
		tri_next = tri_falling_q;
		case (wave_shape_q)
			SHAPE_SAW, SHAPE_PULSE: begin
				sum = ph_ext + eff_ext;
				if (sum > HALF_SW) begin
					sum = sum - FULL_SW;
				end
			end
			default: begin
				sum = tri_falling_q ? (ph_ext - eff2_ext) : (ph_ext + eff2_ext);
			end
		endcase
		acc_next = sum[ACC_BITS-1:0];
		wr_ext   = {{(SW-ACC_BITS){acc_next[ACC_BITS-1]}}, acc_next};

		if (wave_shape_q == SHAPE_TRI || wave_shape_q == SHAPE_SINE) begin
			if (wr_ext > HALF_SW) begin
				tri_next = 1'b1;
			end else if (wr_ext < -HALF_SW) begin
				tri_next = 1'b0;
			end
		end

		if (wave_shape_q == SHAPE_PULSE) begin
			clamped = acc_next[ACC_BITS-1] ? HALF_SW : -HALF_SW;
		end else if (wr_ext > HALF_SW) begin
			clamped = HALF_SW;
		end else if (wr_ext < -HALF_SW) begin
			clamped = -HALF_SW;
		end else begin
			clamped = wr_ext;
		end

		// Rescale to 2^24 full scale
		if (PHASE_FRAC_BITS >= 24) begin
			scaled = ((clamped + HALF_SW) >>> DN_SH) - OUT_HALF_SW;
		end else begin
			scaled = clamped <<< UP_SH;
		end
		wave_next = scaled[WAVE_W-1:0];
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_shape_q <= SHAPE_SAW;
		end else if (cfg_we) begin
			wave_shape_q <= cfg_wdata;
		end
	end

	// Valid flags and oscillator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
			phase_acc_q   <= '0;
			tri_falling_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= step_ch.valid;
			end
			if (adv) begin
				out_valid_q <= valid_s1;
			end
			if (adv && valid_s1) begin
				phase_acc_q   <= acc_next;
				tri_falling_q <= tri_next;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_ready && step_ch.valid) begin
			step_s1 <= step_ch.phase_step;
			fm_s1   <= step_ch.fm_sample;
		end
		if (adv && valid_s1) begin
			wave_q <= wave_next;
		end
	end

	// Checks
	`FMOSC_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv,
		valid_s1 && $stable(step_s1) && $stable(fm_s1),
		"stalled input stage lost its transaction")
	`FMOSC_ASSERT_NOW(a_out_src, $rose(out_valid_q), $past(valid_s1),
		"output valid without an input stage transaction")
	`FMOSC_ASSERT_NEXT(a_pulse_lvl, adv && valid_s1 && wave_shape_q == SHAPE_PULSE,
		wave_q == OUT_HALF || wave_q == -OUT_HALF, "pulse sample is not at full level")

endmodule
